// ===== hw/rtl/bse_pkg.sv =====
`default_nettype none
package bse_pkg;

	localparam logic [1:0] OP_LOAD_FIXED = 2'd0;
	localparam logic [1:0] OP_LOAD_COMP  = 2'd1;
	localparam logic [1:0] OP_SKIN       = 2'd2;
	localparam logic [1:0] OP_UNUSED     = 2'd3;

	localparam int WORDS_PER_BONE = 12;
	localparam int COMP_TRANS_WORDS = 3;
	localparam int ROT_DIVISOR = 32766;
	localparam int ROT_ROUND = 16383;
	localparam int ROT_FOLD_BITS = 14;
	localparam int ROT_FOLD_DIV = 16383;

	typedef struct packed {
		logic [1:0]         operation;
		logic [6:0]         bone_id;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic [16:0]        weight;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               last_weight;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
	} rsp_t;

	function automatic logic [3:0] comp_slot(input logic [3:0] word);
		case (word)
			4'd0:    comp_slot = 4'd3;
			4'd1:    comp_slot = 4'd7;
			4'd2:    comp_slot = 4'd11;
			4'd3:    comp_slot = 4'd0;
			4'd4:    comp_slot = 4'd1;
			4'd5:    comp_slot = 4'd2;
			4'd6:    comp_slot = 4'd4;
			4'd7:    comp_slot = 4'd5;
			4'd8:    comp_slot = 4'd6;
			4'd9:    comp_slot = 4'd8;
			4'd10:   comp_slot = 4'd9;
			4'd11:   comp_slot = 4'd10;
			default: comp_slot = 4'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sh0000_0000_7FFF_FFFF)
			sat32 = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000)
			sat32 = 32'sh8000_0000;
		else
			sat32 = x[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
		if (x[48] != x[47])
			sat48 = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			sat48 = x[47:0];
	endfunction

	function automatic logic signed [31:0] sat48_to_32(input logic signed [47:0] x);
		sat48_to_32 = sat32(64'(x));
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bone_skinning_engine_core.sv =====
`default_nettype none
// Linear blend skinning core. Matrix words (fixed Q.F or compressed) load into
// an on-chip bone table of MAX_BONES*12 words. A fixed or translation word is
// written on its accept; a compressed rotation word passes through the accept,
// fold steps that turn the division by 32766 into adds, and a write of the word
// back. A skin item reads its bone's 12 words through the table's single read
// port, one per cycle, then drains a four-stage multiply/accumulate pipeline;
// the response is emitted only on the last weight, and the emit waits while an
// earlier vertex is still held at the output. A skin item naming a bone of
// MAX_BONES or above adds nothing. Reading a bone word never written returns
// garbage.
module bone_skinning_engine_core #(
	parameter int MAX_BONES = 128,
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  wire bse_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output bse_pkg::rsp_t       rsp
);

	localparam int DEPTH = MAX_BONES * bse_pkg::WORDS_PER_BONE;
	localparam int AW = $clog2(DEPTH);
	localparam int NW = 17 + FRAC_BITS;
	localparam int DIV_STEPS = 4;
	localparam int CW = 3;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	bse_pkg::req_t item_q;

	logic [31:0] bone_mem [DEPTH];
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;

	logic accept;
	logic emit;
	logic bone_ok;
	logic [3:0] slot;
	logic [AW-1:0] ld_addr;
	logic signed [16:0] cv;
	logic signed [63:0] trans_val;
	logic [16:0] cmag;

	logic [NW-1:0] fold_y_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] dcnt_q;
	logic dneg_q;
	logic [AW-1:0] daddr_q;
	logic [NW-1:0] fold_hi;
	logic [NW-1:0] fold_next;
	logic [NW-1:0] quo_fin;
	logic signed [32:0] rot_val;

	logic [AW-1:0] base_q;
	logic [3:0] cnt_q;
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic [3:0] k_s1, k_s2;
	logic [31:0] rd_s1;
	logic signed [63:0] prod_p_s2, prod_n_s2;
	logic signed [31:0] e_s2;
	logic signed [63:0] psum_q, nsum_q;
	logic signed [31:0] p_s3, n_s3;
	logic [1:0] row_s3, row_s4;
	logic signed [49:0] pw_s4, nw_s4;
	logic signed [47:0] pacc_q [3];
	logic signed [47:0] nacc_q [3];
	logic signed [31:0] off_sel, nrm_sel;
	logic signed [63:0] sh_p, sh_n;
	logic drained;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign emit = (state_q == ST_FIN) && item_q.last_weight && (!rsp_valid || rsp_ready);

	assign bone_ok = (11'(req.bone_id) < 11'(MAX_BONES));
	assign slot = (req.operation == bse_pkg::OP_LOAD_FIXED) ? req.element_index
		: bse_pkg::comp_slot(req.element_index);
	assign ld_addr = AW'(11'({req.bone_id, 3'b000}) + 11'({req.bone_id, 2'b00})
		+ 11'(slot));
	assign cv = $signed({1'b0, req.element_value[15:0]}) - 17'sd32768;
	assign trans_val = 64'(cv) <<< (FRAC_BITS - 6);
	assign cmag = cv[16] ? 17'(-cv) : 17'(cv);

	assign fold_hi = fold_y_q >> bse_pkg::ROT_FOLD_BITS;
	assign fold_next = fold_hi + NW'(fold_y_q[bse_pkg::ROT_FOLD_BITS-1:0]);
	assign quo_fin = quo_q + NW'(fold_y_q >= NW'(bse_pkg::ROT_FOLD_DIV));
	assign rot_val = dneg_q ? -33'(quo_fin) : 33'(quo_fin);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = ld_addr;
		mem_wdata = req.element_value;
		if (accept && bone_ok && req.element_index < 4'(bse_pkg::WORDS_PER_BONE)) begin
			if (req.operation == bse_pkg::OP_LOAD_FIXED) begin
				mem_we = 1'b1;
			end else if (req.operation == bse_pkg::OP_LOAD_COMP &&
					req.element_index < 4'(bse_pkg::COMP_TRANS_WORDS)) begin
				mem_we = 1'b1;
				mem_wdata = bse_pkg::sat32(trans_val);
			end
		end
		if (state_q == ST_DIV && dcnt_q == '0) begin
			mem_we = 1'b1;
			mem_waddr = daddr_q;
			mem_wdata = rot_val[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			bone_mem[mem_waddr] <= mem_wdata;
		rd_s1 <= bone_mem[base_q + AW'(cnt_q)];
	end

	assign drained = (cnt_q == 4'(bse_pkg::WORDS_PER_BONE)) && !v1_s1 && !v2_s2
		&& !v3_s3 && !v4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			dcnt_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (emit)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == bse_pkg::OP_LOAD_COMP && bone_ok &&
								req.element_index >= 4'(bse_pkg::COMP_TRANS_WORDS) &&
								req.element_index < 4'(bse_pkg::WORDS_PER_BONE)) begin
							state_q <= ST_DIV;
							dcnt_q <= CW'(DIV_STEPS);
						end else if (req.operation == bse_pkg::OP_SKIN) begin
							state_q <= bone_ok ? ST_RUN : ST_FIN;
							cnt_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0)
						state_q <= ST_IDLE;
					else
						dcnt_q <= dcnt_q - 1'b1;
				end
				ST_RUN: begin
					if (cnt_q != 4'(bse_pkg::WORDS_PER_BONE))
						cnt_q <= cnt_q + 1'b1;
					else if (drained)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!item_q.last_weight || emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pacc_q[i] <= '0;
				nacc_q[i] <= '0;
			end
		end else begin
			v1_s1 <= (state_q == ST_RUN) && (cnt_q != 4'(bse_pkg::WORDS_PER_BONE));
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2 && (k_s2[1:0] == 2'd3);
			v4_s4 <= v3_s3;
			if (v4_s4) begin
				pacc_q[row_s4] <= bse_pkg::sat48(49'(pacc_q[row_s4]) + 49'(pw_s4 >>> 16));
				nacc_q[row_s4] <= bse_pkg::sat48(49'(nacc_q[row_s4]) + 49'(nw_s4 >>> 16));
			end
			if (emit) begin
				for (int i = 0; i < 3; i++) begin
					pacc_q[i] <= '0;
					nacc_q[i] <= '0;
				end
			end
		end
	end

	always_comb begin
		case (k_s1[1:0])
			2'd0:    begin off_sel = item_q.offset_x; nrm_sel = item_q.normal_x; end
			2'd1:    begin off_sel = item_q.offset_y; nrm_sel = item_q.normal_y; end
			default: begin off_sel = item_q.offset_z; nrm_sel = item_q.normal_z; end
		endcase
	end

	assign sh_p = prod_p_s2 >>> FRAC_BITS;
	assign sh_n = prod_n_s2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			base_q <= AW'(11'({req.bone_id, 3'b000}) + 11'({req.bone_id, 2'b00}));
			fold_y_q <= NW'(((NW'(cmag) << FRAC_BITS) + NW'(bse_pkg::ROT_ROUND)) >> 1);
			quo_q <= '0;
			dneg_q <= cv[16];
			daddr_q <= ld_addr;
		end else if (state_q == ST_DIV && dcnt_q != '0) begin
			fold_y_q <= fold_next;
			quo_q <= quo_q + fold_hi;
		end
		k_s1 <= cnt_q;
		k_s2 <= k_s1;
		e_s2 <= rd_s1;
		prod_p_s2 <= $signed(rd_s1) * off_sel;
		prod_n_s2 <= $signed(rd_s1) * nrm_sel;
		if (v2_s2) begin
			case (k_s2[1:0])
				2'd0: begin psum_q <= sh_p; nsum_q <= sh_n; end
				2'd3: begin
					p_s3 <= bse_pkg::sat32(psum_q + 64'(e_s2));
					n_s3 <= bse_pkg::sat32(nsum_q);
					row_s3 <= k_s2[3:2];
				end
				default: begin psum_q <= psum_q + sh_p; nsum_q <= nsum_q + sh_n; end
			endcase
		end
		pw_s4 <= 50'(p_s3) * $signed({1'b0, item_q.weight});
		nw_s4 <= 50'(n_s3) * $signed({1'b0, item_q.weight});
		row_s4 <= row_s3;
		if (emit) begin
			rsp.pos_x <= bse_pkg::sat48_to_32(pacc_q[0]);
			rsp.pos_y <= bse_pkg::sat48_to_32(pacc_q[1]);
			rsp.pos_z <= bse_pkg::sat48_to_32(pacc_q[2]);
			rsp.norm_x <= bse_pkg::sat48_to_32(nacc_q[0]);
			rsp.norm_y <= bse_pkg::sat48_to_32(nacc_q[1]);
			rsp.norm_z <= bse_pkg::sat48_to_32(nacc_q[2]);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bse_checker.sv =====
`default_nettype none
module bse_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                req_valid,
	input wire                req_ready,
	input wire bse_pkg::req_t req,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire bse_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("rsp item changed while stalled");

	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.operation != bse_pkg::OP_SKIN |=> !$rose(rsp_valid))
		else $error("rsp item after a load");

	a_skin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.operation == bse_pkg::OP_SKIN |=> !req_ready)
		else $error("req taken during skin");

endmodule

bind bone_skinning_engine_core bse_checker u_bse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
`default_nettype wire
